// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is applied.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/dsmfd_pkg.sv =====
package dsmfd_pkg;

	localparam int NUM_CHANNELS = 12;
	localparam int FRAME_BYTES  = 16;

	// Derived sizes.
	localparam int WORDS    = (FRAME_BYTES - 2) / 2;
	localparam int FIRST_LO = 3;
	localparam int LAST_LO  = 2 * WORDS + 1;
	localparam int BYTE_AW  = $clog2(FRAME_BYTES);
	localparam int BIDX_W   = $clog2(FRAME_BYTES + 1);
	localparam int CH_AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_PROTOCOL_MODE  = 2'd0;
	localparam logic [1:0] REG_GAP_TICKS      = 2'd1;
	localparam logic [1:0] REG_FAILSAFE_TICKS = 2'd2;

	// Protocol modes.
	localparam logic [1:0] MODE_DSM2   = 2'd0;
	localparam logic [1:0] MODE_DSMX10 = 2'd1;
	localparam logic [1:0] MODE_DSMX11 = 2'd2;

	// Header type codes.
	localparam logic [7:0] HDR_DSM2_A = 8'h01;
	localparam logic [7:0] HDR_DSM2_B = 8'h02;
	localparam logic [7:0] HDR_DSM2_C = 8'h12;
	localparam logic [7:0] HDR_DSMX_A = 8'hA2;
	localparam logic [7:0] HDR_DSMX_B = 8'hB2;

	localparam logic [15:0] EMPTY_SLOT = 16'hffff;

	// Result status codes.
	localparam logic [1:0] ST_ACCEPT  = 2'd0;
	localparam logic [1:0] ST_REJECT  = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	// Input item kinds.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [3:0]  channel_index;
		logic [10:0] channel_value;
		logic        channel_valid;
		logic [1:0]  status;
		logic        last;
	} result_t;

endpackage

// ===== hw/rtl/dsm_receiver_frame_decoder_core.sv =====
// Serial frame decoder for a satellite receiver byte stream.
//
// The item channel (item_valid / item_stall / item) carries either one received
// serial byte or one supervisor timer tick. A transaction completes at a clock
// edge with item_valid high and item_stall low. Results leave on the result
// channel (result_valid / result_stall / result) through one output register.
// Configuration registers are written on the cfg channel, which is always ready.
//
// A byte that does not complete a frame, and a tick that does not time out,
// leave the sequencer idle for the next item. When the last byte of a frame
// arrives, the sequencer checks the header, then walks the stored frame one
// byte per cycle through its single read port, high byte then low byte of
// each 16-bit word. It then emits NUM_CHANNELS results, one per cycle through
// the output register while result_stall is low, or a single result if the
// frame is rejected. item_stall stays high until the last result is loaded,
// also while a failsafe tick emits NUM_CHANNELS timeout results. While high,
// result_stall holds emission and the output register keeps its transaction.
// Reset clears all channels to timed out, disarms frame sync, zeroes the
// counters and loads the register defaults (mode 0, gap 4, failsafe 64).
module dsm_receiver_frame_decoder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  dsmfd_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_stall,
	output dsmfd_pkg::result_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	// Sequencer states.
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_HDR  = 6'b000010,
		S_HI   = 6'b000100,
		S_LO   = 6'b001000,
		S_EMIT = 6'b010000,
		S_REJ  = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [1:0] mode_q;
	logic [7:0] gap_ticks_q;
	logic [7:0] failsafe_ticks_q;

	// Link supervision.
	logic [7:0] gap_q;
	logic [7:0] silence_q;
	logic       armed_q;
	logic [dsmfd_pkg::BIDX_W-1:0] byte_idx_q;

	// Frame buffer, written by the byte stream and read by the decoder.
	logic [7:0] frame_q [dsmfd_pkg::FRAME_BYTES];

	// Channel table.
	logic [10:0] chan_val_q [dsmfd_pkg::NUM_CHANNELS];
	logic        chan_ok_q  [dsmfd_pkg::NUM_CHANNELS];

	// Decoder working registers.
	logic [dsmfd_pkg::BYTE_AW-1:0] rd_ptr_q;
	logic [7:0]                    hi_q;
	logic                          res11_q;
	logic [dsmfd_pkg::CH_AW-1:0]   emit_q;
	logic [1:0]                    emit_st_q;

	// Output register.
	logic               result_valid_q;
	dsmfd_pkg::result_t result_q;

	logic        item_acc;
	logic        is_byte;
	logic        is_tick;
	logic        frame_done;
	logic        gap_hit;
	logic        silence_hit;
	logic        slot_free;
	logic [7:0]  hdr;
	logic        hdr_ok;
	logic        hdr_res11;
	logic [15:0] word;
	logic        word_skip;
	logic        word_bad;
	logic [3:0]  ch_num;
	logic        ch_hit;
	logic [10:0] word_val;
	logic        last_word;
	logic        emit_last;
	logic [10:0] emit_val;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign item_acc    = item_valid && !item_stall;
	assign is_byte     = item_acc && (item.kind == dsmfd_pkg::KIND_BYTE);
	assign is_tick     = item_acc && (item.kind == dsmfd_pkg::KIND_TICK);
	assign frame_done  = is_byte && armed_q &&
		(byte_idx_q == dsmfd_pkg::BIDX_W'(dsmfd_pkg::FRAME_BYTES - 1));
	assign gap_hit     = (gap_q >= gap_ticks_q);
	assign silence_hit = (silence_q >= failsafe_ticks_q);
	assign slot_free   = !result_valid_q || !result_stall;

	// Header type and protocol mode set both acceptance and resolution.
	assign hdr = frame_q[1];
	always_comb begin
		hdr_ok    = 1'b0;
		hdr_res11 = 1'b0;
		if (hdr == dsmfd_pkg::HDR_DSM2_A || hdr == dsmfd_pkg::HDR_DSM2_B ||
		    hdr == dsmfd_pkg::HDR_DSM2_C) begin
			hdr_ok    = (mode_q == dsmfd_pkg::MODE_DSM2);
			hdr_res11 = hdr[4];
		end else if (hdr == dsmfd_pkg::HDR_DSMX_A || hdr == dsmfd_pkg::HDR_DSMX_B) begin
			hdr_ok    = (mode_q == dsmfd_pkg::MODE_DSMX10) ||
			            (mode_q == dsmfd_pkg::MODE_DSMX11);
			hdr_res11 = (mode_q == dsmfd_pkg::MODE_DSMX11);
		end
	end

	// Word decode: the high byte was latched in the previous cycle.
	assign word      = {hi_q, frame_q[rd_ptr_q]};
	assign word_skip = (word == dsmfd_pkg::EMPTY_SLOT);
	assign word_bad  = (rd_ptr_q != dsmfd_pkg::BYTE_AW'(dsmfd_pkg::FIRST_LO)) && word[15];
	assign ch_num    = res11_q ? word[14:11] : word[13:10];
	assign ch_hit    = ({1'b0, ch_num} < 5'(dsmfd_pkg::NUM_CHANNELS));
	assign word_val  = res11_q ? word[10:0] : {1'b0, word[9:0]};
	assign last_word = (rd_ptr_q == dsmfd_pkg::BYTE_AW'(dsmfd_pkg::LAST_LO));

	assign emit_last = (emit_q == dsmfd_pkg::CH_AW'(dsmfd_pkg::NUM_CHANNELS - 1));
	assign emit_val  = chan_ok_q[emit_q] ? chan_val_q[emit_q] : 11'd0;

	// Configuration registers. Writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= dsmfd_pkg::MODE_DSM2;
			gap_ticks_q      <= 8'd4;
			failsafe_ticks_q <= 8'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dsmfd_pkg::REG_PROTOCOL_MODE:  mode_q           <= cfg_data[1:0];
				dsmfd_pkg::REG_GAP_TICKS:      gap_ticks_q      <= cfg_data;
				dsmfd_pkg::REG_FAILSAFE_TICKS: failsafe_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame buffer write side; the sequencer only reads it once the frame is full.
	always_ff @(posedge clk) begin
		if (is_byte && armed_q) begin
			frame_q[byte_idx_q[dsmfd_pkg::BYTE_AW-1:0]] <= item.data_byte;
		end
	end

	// Channel table: cleared by a failsafe tick, written by decoded words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dsmfd_pkg::NUM_CHANNELS; i++) begin
				chan_val_q[i] <= 11'd0;
				chan_ok_q[i]  <= 1'b0;
			end
		end else if (is_tick && silence_hit) begin
			for (int i = 0; i < dsmfd_pkg::NUM_CHANNELS; i++) begin
				chan_val_q[i] <= 11'd0;
				chan_ok_q[i]  <= 1'b0;
			end
		end else if (state_q == S_LO && !word_skip && !word_bad && ch_hit) begin
			chan_val_q[ch_num[dsmfd_pkg::CH_AW-1:0]] <= word_val;
			chan_ok_q[ch_num[dsmfd_pkg::CH_AW-1:0]]  <= 1'b1;
		end
	end

	// Latch the high byte of each word.
	always_ff @(posedge clk) begin
		if (state_q == S_HI) begin
			hi_q <= frame_q[rd_ptr_q];
		end
	end

	// Sequencer and link supervision.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			gap_q      <= 8'd0;
			silence_q  <= 8'd0;
			armed_q    <= 1'b0;
			byte_idx_q <= '0;
			rd_ptr_q   <= '0;
			res11_q    <= 1'b0;
			emit_q     <= '0;
			emit_st_q  <= dsmfd_pkg::ST_ACCEPT;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (is_byte) begin
						gap_q <= 8'd0;
						if (armed_q && byte_idx_q < dsmfd_pkg::BIDX_W'(dsmfd_pkg::FRAME_BYTES)) begin
							byte_idx_q <= byte_idx_q + 1'b1;
						end
						if (frame_done) begin
							armed_q <= 1'b0;
							state_q <= S_HDR;
						end
					end else if (is_tick) begin
						if (gap_hit) begin
							armed_q    <= 1'b1;
							byte_idx_q <= '0;
							gap_q      <= 8'd0;
						end else begin
							gap_q <= gap_q + 8'd1;
						end
						if (silence_hit) begin
							silence_q <= 8'd0;
							emit_q    <= '0;
							emit_st_q <= dsmfd_pkg::ST_TIMEOUT;
							state_q   <= S_EMIT;
						end else begin
							silence_q <= silence_q + 8'd1;
						end
					end
				end
				S_HDR: begin
					res11_q  <= hdr_res11;
					rd_ptr_q <= dsmfd_pkg::BYTE_AW'(2);
					state_q  <= hdr_ok ? S_HI : S_REJ;
				end
				S_HI: begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
					state_q  <= S_LO;
				end
				S_LO: begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
					if (!word_skip && word_bad) begin
						state_q <= S_REJ;
					end else if (last_word) begin
						silence_q <= 8'd0;
						emit_q    <= '0;
						emit_st_q <= dsmfd_pkg::ST_ACCEPT;
						state_q   <= S_EMIT;
					end else begin
						state_q <= S_HI;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						if (emit_last) begin
							emit_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							emit_q <= emit_q + 1'b1;
						end
					end
				end
				S_REJ: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: loaded when the slot is free, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT || state_q == S_REJ) && slot_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && slot_free) begin
			result_q.channel_index <= 4'(emit_q);
			result_q.channel_value <= emit_val;
			result_q.channel_valid <= chan_ok_q[emit_q];
			result_q.status        <= emit_st_q;
			result_q.last          <= emit_last;
		end else if (state_q == S_REJ && slot_free) begin
			result_q.channel_index <= 4'd0;
			result_q.channel_value <= 11'd0;
			result_q.channel_valid <= 1'b0;
			result_q.status        <= dsmfd_pkg::ST_REJECT;
			result_q.last          <= 1'b1;
		end
	end

endmodule

// ===== hw/rtl/dsmfd_checker.sv =====
`include "assert_macros.svh"

module dsmfd_checker (
	input logic               clk,
	input logic               arst_n,
	input dsmfd_pkg::result_t result,
	input logic               result_valid,
	input logic               result_stall
);

	// A stalled transaction keeps its payload.
	`ASSERT_CLK(a_result_hold, clk, arst_n, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

	// A rejected frame gives one empty result that closes the run.
	`ASSERT_NEVER(a_reject_form, clk, arst_n, result_valid && result.status == dsmfd_pkg::ST_REJECT && (!result.last || result.channel_index != 4'd0 || result.channel_valid), "malformed reject result")

	// A channel without data always reports a zero value.
	`ASSERT_NEVER(a_invalid_zero, clk, arst_n, result_valid && !result.channel_valid && result.channel_value != 11'd0, "timed-out channel carries a value")

	// Timeout results never carry live channels, and no unknown status appears.
	`ASSERT_NEVER(a_status_form, clk, arst_n, result_valid && ((result.status == dsmfd_pkg::ST_TIMEOUT && result.channel_valid) || result.status == 2'd3), "bad status on result")

endmodule

bind dsm_receiver_frame_decoder_core dsmfd_checker u_dsmfd_checker (.*);
